@@ src/bpa_pkg.sv @@
// Shared types and constants for the buddy page allocator.
package bpa_pkg;

    localparam int PAGES_DEF = 1024;
    localparam int CNT_W = 11;
    localparam int OFF_W = 10;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [CNT_W-1:0] USABLE_RESET = 11'd1024;
    localparam logic [APB_AW-1:0] ADDR_USABLE = 3'd0;

    typedef enum logic [1:0] {
        OP_INIT  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INIT_ROOT,
        ST_INIT_STEP,
        ST_INIT_RIGHT,
        ST_AL_START,
        ST_AL_ROOT,
        ST_AL_LOOP,
        ST_AL_SPLIT,
        ST_AL_RDL,
        ST_AL_RDR,
        ST_UP_RD,
        ST_UP_WR,
        ST_FREE_MARK,
        ST_DONE
    } state_t;

endpackage

@@ src/bpa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

@@ src/buddy_page_allocator_unit.sv @@
// Buddy page allocator: size-mask tree in one RAM, walked by a sequencer.
// Allocate: walks down the tree from the root, splitting whole-free blocks on the way,
// then climbs back to the root updating each parent from its two children.
// Free: marks the block, then climbs the same way. Init: clearing sweep, then usable count.
// One transaction in flight; the single RAM read port sets the step rate.
// After reset a clearing sweep of all 2*PAGES entries runs before any transaction is taken.
module buddy_page_allocator_unit #(
    parameter int PAGES = bpa_pkg::PAGES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_operation,
    input  logic [bpa_pkg::CNT_W-1:0]     s_page_count,
    input  logic [bpa_pkg::OFF_W-1:0]     s_page_offset,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_status,
    output logic [bpa_pkg::OFF_W-1:0]     m_granted_offset,
    output logic [bpa_pkg::CNT_W-1:0]     m_free_page_total,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bpa_pkg::APB_AW-1:0]    paddr,
    input  logic [bpa_pkg::APB_DW-1:0]    pwdata,
    output logic [bpa_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    localparam int LVL = $clog2(PAGES);
    localparam int VW = LVL + 1;
    localparam int AW = LVL + 1;
    localparam int XW = (VW > bpa_pkg::CNT_W) ? VW : bpa_pkg::CNT_W;
    localparam int DEPTH = 2 * PAGES;

    function automatic logic [VW-1:0] round_pow2(input logic [VW-1:0] n);
        logic [VW-1:0] m;
        m = n - VW'(1);
        for (int k = 0; k < 5; k++) begin
            m = m | (m >> (1 << k));
        end
        return m + VW'(1);
    endfunction

    bpa_pkg::state_t state_reg, state_next;
    logic [AW-1:0]  addr_reg, addr_next;
    logic           init_reg, init_next;
    logic [AW-1:0]  node_reg, node_next;
    logic [VW-1:0]  span_reg, span_next;
    logic [VW-1:0]  cur_reg, cur_next;
    logic [VW-1:0]  lv_reg, lv_next;
    logic [VW-1:0]  len_reg, len_next;
    logic [VW-1:0]  left_reg, left_next;
    logic [VW-1:0]  cnt_reg, cnt_next;
    logic [LVL-1:0] first_reg, first_next;
    logic           over_reg, over_next;
    logic           free_reg, free_next;
    logic           status_reg, status_next;
    logic [LVL-1:0] gr_reg, gr_next;
    logic [bpa_pkg::CNT_W-1:0] usable_reg;
    logic           mv_reg, mv_next;
    logic           ms_reg, ms_next;
    logic [bpa_pkg::OFF_W-1:0] mg_reg, mg_next;
    logic [bpa_pkg::CNT_W-1:0] mt_reg, mt_next;

    logic           ram_we;
    logic [AW-1:0]  ram_waddr, ram_raddr;
    logic [VW-1:0]  ram_wdata, ram_rdata;

    // request decode
    logic [XW-1:0]  cnt_x, off_x, usable_x;
    logic           req_over;
    logic [VW-1:0]  cnt_sat, req_len, usable_sat;
    logic [AW-1:0]  leaf, free_node;
    logic [AW-1:0]  lchild, rchild;
    logic [VW-1:0]  half, parent_val;
    logic [VW:0]    cnt_sum;
    logic [XW-1:0]  gr_x, mt_x;

    always_comb begin
        cnt_x = (s_page_count == '0) ? XW'(1) : XW'(s_page_count);
        req_over = cnt_x > XW'(PAGES);
        cnt_sat = req_over ? VW'(PAGES) : cnt_x[VW-1:0];
        req_len = round_pow2(cnt_sat);
        off_x = XW'(s_page_offset) & XW'(PAGES - 1);
        leaf = AW'(PAGES) | off_x[AW-1:0];
        free_node = leaf;
        for (int i = 0; i < VW; i++) begin
            if (req_len[i]) begin
                free_node = leaf >> i;
            end
        end
        usable_x = XW'(usable_reg);
        usable_sat = (usable_x > XW'(PAGES)) ? VW'(PAGES) : usable_x[VW-1:0];
    end

    assign lchild = {node_reg[AW-2:0], 1'b0};
    assign rchild = {node_reg[AW-2:0], 1'b1};
    assign half = span_reg >> 1;
    assign cnt_sum = {1'b0, cnt_reg} + {1'b0, len_reg};
    assign parent_val = (free_reg && cur_reg == span_reg && ram_rdata == span_reg) ?
                        VW'({span_reg, 1'b0}) : (cur_reg | ram_rdata);

    always_comb begin
        state_next = state_reg;
        addr_next = addr_reg;
        init_next = init_reg;
        node_next = node_reg;
        span_next = span_reg;
        cur_next = cur_reg;
        lv_next = lv_reg;
        len_next = len_reg;
        left_next = left_reg;
        cnt_next = cnt_reg;
        first_next = first_reg;
        over_next = over_reg;
        free_next = free_reg;
        status_next = status_reg;
        gr_next = gr_reg;
        mv_next = mv_reg;
        ms_next = ms_reg;
        mg_next = mg_reg;
        mt_next = mt_reg;
        ram_we = 1'b0;
        ram_waddr = node_reg;
        ram_wdata = '0;
        ram_raddr = node_reg;
        gr_x = XW'(gr_reg);
        mt_x = XW'(cnt_reg);

        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end

        unique case (state_reg)
            bpa_pkg::ST_CLEAR: begin
                ram_we = 1'b1;
                ram_waddr = addr_reg;
                addr_next = addr_reg + AW'(1);
                if (addr_reg == AW'(DEPTH - 1)) begin
                    state_next = init_reg ? bpa_pkg::ST_INIT_ROOT : bpa_pkg::ST_IDLE;
                end
            end
            bpa_pkg::ST_IDLE: begin
                if (s_valid) begin
                    len_next = req_len;
                    over_next = req_over;
                    status_next = 1'b0;
                    gr_next = '0;
                    first_next = '0;
                    span_next = VW'(PAGES);
                    addr_next = '0;
                    unique case (bpa_pkg::op_t'(s_operation))
                        bpa_pkg::OP_INIT: begin
                            init_next = 1'b1;
                            state_next = bpa_pkg::ST_CLEAR;
                        end
                        bpa_pkg::OP_ALLOC: begin
                            node_next = AW'(1);
                            free_next = 1'b0;
                            state_next = bpa_pkg::ST_AL_START;
                        end
                        bpa_pkg::OP_FREE: begin
                            node_next = free_node;
                            free_next = 1'b1;
                            state_next = bpa_pkg::ST_FREE_MARK;
                        end
                        default: begin
                            state_next = bpa_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            bpa_pkg::ST_INIT_ROOT: begin
                init_next = 1'b0;
                ram_we = 1'b1;
                ram_waddr = AW'(1);
                ram_wdata = usable_sat;
                cnt_next = usable_sat;
                left_next = usable_sat;
                node_next = AW'(1);
                state_next = bpa_pkg::ST_INIT_STEP;
            end
            bpa_pkg::ST_INIT_STEP: begin
                if (left_reg != '0 && left_reg < span_reg) begin
                    ram_we = 1'b1;
                    ram_waddr = lchild;
                    span_next = half;
                    if (left_reg > half) begin
                        ram_wdata = half;
                        left_next = left_reg - half;
                        node_next = rchild;
                        state_next = bpa_pkg::ST_INIT_RIGHT;
                    end else begin
                        ram_wdata = left_reg;
                        node_next = lchild;
                    end
                end else begin
                    state_next = bpa_pkg::ST_DONE;
                end
            end
            bpa_pkg::ST_INIT_RIGHT: begin
                ram_we = 1'b1;
                ram_wdata = left_reg;
                state_next = bpa_pkg::ST_INIT_STEP;
            end
            bpa_pkg::ST_AL_START: begin
                ram_raddr = AW'(1);
                if (over_reg) begin
                    status_next = 1'b1;
                    state_next = bpa_pkg::ST_DONE;
                end else begin
                    state_next = bpa_pkg::ST_AL_ROOT;
                end
            end
            bpa_pkg::ST_AL_ROOT: begin
                cur_next = ram_rdata;
                state_next = bpa_pkg::ST_AL_LOOP;
            end
            bpa_pkg::ST_AL_LOOP: begin
                priority if (len_reg <= cur_reg && len_reg < span_reg) begin
                    if (cur_reg == span_reg) begin
                        // whole-free: split into two halves, go left
                        ram_we = 1'b1;
                        ram_waddr = lchild;
                        ram_wdata = cur_reg >> 1;
                        state_next = bpa_pkg::ST_AL_SPLIT;
                    end else begin
                        ram_raddr = lchild;
                        state_next = bpa_pkg::ST_AL_RDL;
                    end
                end else if (len_reg > cur_reg) begin
                    status_next = 1'b1;
                    state_next = bpa_pkg::ST_DONE;
                end else begin
                    ram_we = 1'b1;
                    ram_wdata = '0;
                    cnt_next = (cnt_reg > len_reg) ? cnt_reg - len_reg : '0;
                    gr_next = first_reg;
                    cur_next = '0;
                    state_next = (node_reg == AW'(1)) ? bpa_pkg::ST_DONE : bpa_pkg::ST_UP_RD;
                end
            end
            bpa_pkg::ST_AL_SPLIT: begin
                ram_we = 1'b1;
                ram_waddr = rchild;
                ram_wdata = cur_reg >> 1;
                cur_next = cur_reg >> 1;
                node_next = lchild;
                span_next = half;
                state_next = bpa_pkg::ST_AL_LOOP;
            end
            bpa_pkg::ST_AL_RDL: begin
                lv_next = ram_rdata;
                ram_raddr = rchild;
                state_next = bpa_pkg::ST_AL_RDR;
            end
            bpa_pkg::ST_AL_RDR: begin
                span_next = half;
                state_next = bpa_pkg::ST_AL_LOOP;
                priority if ((len_reg & lv_reg) != '0) begin
                    node_next = lchild;
                    cur_next = lv_reg;
                end else if ((len_reg & ram_rdata) != '0) begin
                    node_next = rchild;
                    cur_next = ram_rdata;
                    first_next = first_reg + LVL'(half);
                end else if (len_reg <= lv_reg) begin
                    node_next = lchild;
                    cur_next = lv_reg;
                end else if (len_reg <= ram_rdata) begin
                    node_next = rchild;
                    cur_next = ram_rdata;
                    first_next = first_reg + LVL'(half);
                end else begin
                    span_next = span_reg;
                    status_next = 1'b1;
                    state_next = bpa_pkg::ST_DONE;
                end
            end
            bpa_pkg::ST_FREE_MARK: begin
                ram_we = 1'b1;
                ram_wdata = len_reg;
                cur_next = len_reg;
                span_next = len_reg;
                cnt_next = (cnt_sum > (VW+1)'(PAGES)) ? VW'(PAGES) : cnt_sum[VW-1:0];
                state_next = (node_reg == AW'(1)) ? bpa_pkg::ST_DONE : bpa_pkg::ST_UP_RD;
            end
            bpa_pkg::ST_UP_RD: begin
                ram_raddr = {node_reg[AW-1:1], ~node_reg[0]};
                state_next = bpa_pkg::ST_UP_WR;
            end
            bpa_pkg::ST_UP_WR: begin
                // sibling is in ram_rdata; merge on free when both halves are whole-free
                ram_we = 1'b1;
                ram_waddr = node_reg >> 1;
                ram_wdata = parent_val;
                cur_next = parent_val;
                span_next = VW'({span_reg, 1'b0});
                node_next = node_reg >> 1;
                state_next = ((node_reg >> 1) == AW'(1)) ? bpa_pkg::ST_DONE
                                                         : bpa_pkg::ST_UP_RD;
            end
            bpa_pkg::ST_DONE: begin
                if (!mv_reg || m_ready) begin
                    mv_next = 1'b1;
                    ms_next = status_reg;
                    mg_next = gr_x[bpa_pkg::OFF_W-1:0];
                    mt_next = mt_x[bpa_pkg::CNT_W-1:0];
                    state_next = bpa_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bpa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bpa_pkg::ST_CLEAR;
            addr_reg <= '0;
            init_reg <= 1'b0;
            cnt_reg <= '0;
            mv_reg <= 1'b0;
            usable_reg <= bpa_pkg::USABLE_RESET;
        end else begin
            state_reg <= state_next;
            addr_reg <= addr_next;
            init_reg <= init_next;
            cnt_reg <= cnt_next;
            mv_reg <= mv_next;
            if (psel && penable && pwrite && paddr[2] == bpa_pkg::ADDR_USABLE[2]) begin
                usable_reg <= pwdata[bpa_pkg::CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        node_reg <= node_next;
        span_reg <= span_next;
        cur_reg <= cur_next;
        lv_reg <= lv_next;
        len_reg <= len_next;
        left_reg <= left_next;
        first_reg <= first_next;
        over_reg <= over_next;
        free_reg <= free_next;
        status_reg <= status_next;
        gr_reg <= gr_next;
        ms_reg <= ms_next;
        mg_reg <= mg_next;
        mt_reg <= mt_next;
    end

    bpa_ram #(
        .WIDTH(VW),
        .DEPTH(DEPTH)
    ) u_tree (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_ready = (state_reg == bpa_pkg::ST_IDLE);
    assign m_valid = mv_reg;
    assign m_status = ms_reg;
    assign m_granted_offset = mg_reg;
    assign m_free_page_total = mt_reg;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == bpa_pkg::ADDR_USABLE[2]) ?
                    bpa_pkg::APB_DW'(usable_reg) : '0;

endmodule

@@ src/bpa_checker.sv @@
// Port-level checks for the buddy page allocator, bound to the top level.
module bpa_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic                      m_status,
    input logic [bpa_pkg::OFF_W-1:0] m_granted_offset,
    input logic [bpa_pkg::CNT_W-1:0] m_free_page_total
);

    // no result straight out of reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status)
            && $stable(m_granted_offset) && $stable(m_free_page_total))
        else $error("stalled result changed");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> m_granted_offset == '0)
        else $error("failed allocation with non-zero offset");

    // one transaction in flight at a time
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while busy");

endmodule

bind buddy_page_allocator_unit bpa_checker u_bpa_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_status          (m_status),
    .m_granted_offset  (m_granted_offset),
    .m_free_page_total (m_free_page_total)
);
